>>> rtl/cgrb_pkg.sv
// Shared types, codes and constants of the clipped glyph row blitter.
package cgrb_pkg;

   localparam int MASK_BITS = 32;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 80;
   localparam int ENTRY_W = 18;

   localparam logic [1:0] CMD_DRAW = 2'd0;
   localparam logic [1:0] CMD_WORD = 2'd1;
   localparam logic [1:0] CMD_TABLE = 2'd2;

   localparam logic [1:0] CSR_FIRST_CHAR = 2'd0;
   localparam logic [1:0] CSR_GLYPH_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_SPACE_WIDTH = 2'd2;
   localparam logic [1:0] CSR_MONO_WIDTH = 2'd3;

   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_SPACE = 8'd32;

   typedef struct packed {
      logic [7:0] first_char;
      logic [5:0] glyph_height;
      logic [5:0] space_width;
      logic [5:0] mono_width;
   } cgrb_cfg_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] char_code;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [11:0] clip_left;
      logic [11:0] clip_top;
      logic [11:0] clip_right;
      logic [11:0] clip_bottom;
      logic [15:0] color;
      logic [11:0] word_address;
      logic [15:0] word_value;
      logic [5:0] glyph_width;
   } cgrb_req_type;

   typedef struct packed {
      logic [11:0] row_y;
      logic [11:0] base_x;
      logic [31:0] write_mask;
      logic [15:0] pixel_color;
      logic row_valid;
      logic [5:0] advance;
      logic bad_code;
      logic last;
   } cgrb_rsp_type;

   typedef struct packed {
      logic [5:0] width;
      logic [11:0] offset;
   } cgrb_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_LOOKUP,
      ST_SETUP,
      ST_CLIP,
      ST_FETCH,
      ST_LAND,
      ST_EMIT,
      ST_SINGLE
   } cgrb_state_type;

endpackage

>>> rtl/cgrb_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
module cgrb_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cgrb_engine.sv
// Command sequencer: glyph and table stores, clipping setup and the per-row fetch loop.
module cgrb_engine #(
   parameter int GLYPH_WORDS = 4096,
   parameter int TABLE_ENTRIES = 256,
   parameter int MAX_GLYPH_WIDTH = 32,
   parameter int MAX_GLYPH_HEIGHT = 32
) (
   input  logic clock,
   input  logic reset,
   input  cgrb_pkg::cgrb_cfg_type cfg,
   input  logic req_valid,
   output logic req_ready,
   input  cgrb_pkg::cgrb_req_type req,
   output logic rsp_valid,
   input  logic rsp_ready,
   output cgrb_pkg::cgrb_rsp_type rsp
);
   import cgrb_pkg::*;

   localparam int AW = $clog2(GLYPH_WORDS);
   localparam int SW = AW + 1;
   localparam int TAW = $clog2(TABLE_ENTRIES);
   localparam int POS_W = 11;
   localparam int HCAP = (MAX_GLYPH_HEIGHT < MASK_BITS) ? MAX_GLYPH_HEIGHT : MASK_BITS;

   function automatic logic signed [13:0] sx14(input logic [11:0] v);
      sx14 = {{2{v[11]}}, v};
   endfunction

   function automatic logic [31:0] low_mask(input logic [5:0] n);
      logic [32:0] t;
      t = (33'd1 << n) - 33'd1;
      low_mask = t[31:0];
   endfunction

   function automatic logic [5:0] clamp_lo(input logic signed [13:0] d);
      if (d < 14'sd0) begin
         clamp_lo = 6'd0;
      end else if (d > 14'sd32) begin
         clamp_lo = 6'd32;
      end else begin
         clamp_lo = d[5:0];
      end
   endfunction

   function automatic logic [5:0] clamp_hi(input logic signed [13:0] d, input logic [5:0] lim);
      if (d <= 14'sd0) begin
         clamp_hi = 6'd0;
      end else if (d < $signed({8'd0, lim})) begin
         clamp_hi = d[5:0];
      end else begin
         clamp_hi = lim;
      end
   endfunction

   cgrb_state_type state_ff, state_in;
   cgrb_req_type req_ff, req_in;
   logic [TAW-1:0] tab_addr_ff, tab_addr_in;
   logic [5:0] ppr_ff, ppr_in;
   logic [11:0] off_ff, off_in;
   logic [5:0] adv_ff, adv_in;
   logic bad_ff, bad_in;
   logic signed [13:0] dtop_ff, dtop_in, dbot_ff, dbot_in;
   logic signed [13:0] dleft_ff, dleft_in, dright_ff, dright_in;
   logic [5:0] r_ff, r_in, r1_ff, r1_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [POS_W-1:0] p_ff, p_in;
   logic [1:0] k_ff, k_in;
   logic [47:0] win_ff, win_in;
   logic [31:0] colmask_ff, colmask_in;
   logic out_valid_ff, out_valid_in;
   cgrb_rsp_type out_ff, out_in;

   logic w_we, w_re;
   logic [AW-1:0] w_waddr, w_raddr;
   logic [15:0] w_rdata;
   logic t_we, t_re;
   logic [ENTRY_W-1:0] t_rdata;
   cgrb_entry_type t_wdata, t_ent;

   logic out_free, is_newline, is_space, code_ok, table_ok, word_ok, off_big;
   logic empty, last_row;
   logic [7:0] code_idx;
   logic [5:0] wsat, hmax, clim;
   logic [SW-1:0] fetch_sum;
   logic [47:0] shifted;
   logic [31:0] row_mask;

   cgrb_ram #(.DEPTH(GLYPH_WORDS), .WIDTH(16)) u_word_ram (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(req.word_value),
      .rd_en(w_re), .rd_addr(w_raddr), .rd_data(w_rdata)
   );

   cgrb_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(ENTRY_W)) u_table_ram (
      .clock(clock), .wr_en(t_we), .wr_addr(tab_addr_ff), .wr_data(t_wdata),
      .rd_en(t_re), .rd_addr(tab_addr_ff), .rd_data(t_rdata)
   );

   assign out_free = !out_valid_ff || rsp_ready;
   assign is_newline = (req.char_code == CODE_NEWLINE);
   assign is_space = (req.char_code == CODE_SPACE);
   assign code_idx = req.char_code - cfg.first_char;
   assign code_ok = (req.char_code >= cfg.first_char) &&
                    (11'(code_idx) < 11'(TABLE_ENTRIES));
   assign table_ok = (11'(req.char_code) < 11'(TABLE_ENTRIES));
   assign word_ok = (17'(req.word_address) < 17'(GLYPH_WORDS));
   assign off_big = (17'(off_ff) >= 17'(GLYPH_WORDS));
   assign wsat = ({1'b0, req.glyph_width} > 7'(MAX_GLYPH_WIDTH)) ?
                 6'(MAX_GLYPH_WIDTH) : req.glyph_width;
   assign hmax = (cfg.glyph_height > 6'(HCAP)) ? 6'(HCAP) : cfg.glyph_height;
   assign t_ent = t_rdata;
   assign clim = (t_ent.width > 6'd32) ? 6'd32 : t_ent.width;
   assign empty = (r_ff >= r1_ff) || (c0_ff >= c1_ff);
   assign last_row = (6'(r_ff + 6'd1) == r1_ff);
   assign fetch_sum = SW'(off_ff) + SW'(p_ff[POS_W-1:4]) + SW'(k_ff);
   assign shifted = win_ff << p_ff[3:0];

   always_comb begin
      for (int c = 0; c < MASK_BITS; c++) begin
         row_mask[c] = shifted[47-c] & colmask_ff[c];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req.command)
                  CMD_DRAW: begin
                     if (is_newline || is_space || !code_ok) begin
                        state_in = ST_SINGLE;
                     end else begin
                        state_in = ST_LOOKUP;
                     end
                  end
                  CMD_TABLE: begin
                     if (table_ok) begin
                        state_in = ST_REDUCE;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_REDUCE: begin
            if (!off_big) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOKUP: state_in = ST_SETUP;
         ST_SETUP: state_in = ST_CLIP;
         ST_CLIP: state_in = empty ? ST_SINGLE : ST_FETCH;
         ST_FETCH: begin
            if (k_ff == 2'd2) begin
               state_in = ST_LAND;
            end
         end
         ST_LAND: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = last_row ? ST_IDLE : ST_FETCH;
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      tab_addr_in = tab_addr_ff;
      ppr_in = ppr_ff;
      off_in = off_ff;
      adv_in = adv_ff;
      bad_in = bad_ff;
      dtop_in = dtop_ff;
      dbot_in = dbot_ff;
      dleft_in = dleft_ff;
      dright_in = dright_ff;
      r_in = r_ff;
      r1_in = r1_ff;
      c0_in = c0_ff;
      c1_in = c1_ff;
      p_in = p_ff;
      k_in = k_ff;
      win_in = win_ff;
      colmask_in = colmask_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      req_ready = 1'b0;
      w_we = 1'b0;
      w_waddr = AW'(req.word_address);
      w_re = 1'b0;
      w_raddr = AW'((fetch_sum >= SW'(GLYPH_WORDS)) ? fetch_sum - SW'(GLYPH_WORDS) : fetch_sum);
      t_we = 1'b0;
      t_re = 1'b0;
      t_wdata.width = ppr_ff;
      t_wdata.offset = off_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req;
               case (req.command)
                  CMD_WORD: w_we = word_ok;
                  CMD_TABLE: begin
                     tab_addr_in = TAW'(req.char_code);
                     ppr_in = wsat;
                     off_in = req.word_address;
                  end
                  CMD_DRAW: begin
                     tab_addr_in = TAW'(code_idx);
                     adv_in = is_space ? cfg.space_width : 6'd0;
                     bad_in = !is_newline && !is_space && !code_ok;
                  end
                  default: req_in = req;
               endcase
            end
         end
         ST_REDUCE: begin
            if (off_big) begin
               off_in = off_ff - 12'(GLYPH_WORDS);
            end else begin
               t_we = 1'b1;
            end
         end
         ST_LOOKUP: begin
            t_re = 1'b1;
            dtop_in = sx14(req_ff.clip_top) - sx14(req_ff.pos_y);
            dbot_in = sx14(req_ff.clip_bottom) - sx14(req_ff.pos_y) + 14'sd1;
            dleft_in = sx14(req_ff.clip_left) - sx14(req_ff.pos_x);
            dright_in = sx14(req_ff.clip_right) - sx14(req_ff.pos_x) + 14'sd1;
         end
         ST_SETUP: begin
            ppr_in = t_ent.width;
            off_in = t_ent.offset;
            adv_in = (cfg.mono_width != 6'd0) ? cfg.mono_width : t_ent.width;
            bad_in = 1'b0;
            r_in = clamp_lo(dtop_ff);
            r1_in = clamp_hi(dbot_ff, hmax);
            c0_in = clamp_lo(dleft_ff);
            c1_in = clamp_hi(dright_ff, clim);
         end
         ST_CLIP: begin
            p_in = POS_W'(r_ff * ppr_ff);
            colmask_in = low_mask(c1_ff) & ~low_mask(c0_ff);
            k_in = 2'd0;
         end
         ST_FETCH: begin
            w_re = 1'b1;
            if (k_ff != 2'd0) begin
               win_in = {win_ff[31:0], w_rdata};
            end
            k_in = (k_ff == 2'd2) ? 2'd0 : 2'(k_ff + 2'd1);
         end
         ST_LAND: win_in = {win_ff[31:0], w_rdata};
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.row_y = req_ff.pos_y + 12'(r_ff);
               out_in.base_x = req_ff.pos_x;
               out_in.write_mask = row_mask;
               out_in.pixel_color = req_ff.color;
               out_in.row_valid = 1'b1;
               out_in.advance = last_row ? adv_ff : 6'd0;
               out_in.bad_code = 1'b0;
               out_in.last = last_row;
               r_in = 6'(r_ff + 6'd1);
               p_in = POS_W'(p_ff + POS_W'(ppr_ff));
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in.row_y = 12'd0;
               out_in.base_x = 12'd0;
               out_in.write_mask = 32'd0;
               out_in.pixel_color = req_ff.color;
               out_in.row_valid = 1'b0;
               out_in.advance = adv_ff;
               out_in.bad_code = bad_ff;
               out_in.last = 1'b1;
            end
         end
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         k_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         k_ff <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      tab_addr_ff <= tab_addr_in;
      ppr_ff <= ppr_in;
      off_ff <= off_in;
      adv_ff <= adv_in;
      bad_ff <= bad_in;
      dtop_ff <= dtop_in;
      dbot_ff <= dbot_in;
      dleft_ff <= dleft_in;
      dright_ff <= dright_in;
      r_ff <= r_in;
      r1_ff <= r1_in;
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      p_ff <= p_in;
      win_ff <= win_in;
      colmask_ff <= colmask_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp = out_ff;

endmodule

>>> rtl/clipped_glyph_row_blitter_unit.sv
// Top level of the clipped glyph row blitter: ports, configuration registers, item packing.
//
//   Channel  Direction  Payload                                   Handshake
//   req      in         tuser command, tdata draw/load fields     tvalid/tready
//   rsp      out        tdata row write, tuser flags, tlast       tvalid/tready
//   csr      in         register index and data                   csr_we only
//
// A glyph word load writes the word in the idle step. A table load subtracts
// GLYPH_WORDS from the offset in the reduce step until it is in range, then
// writes the entry. A draw runs the lookup, setup and clip steps and then, for
// each visible row, reads the glyph word memory three times, lands the last word
// and emits the row; a draw with a single result emits it from the single step.
// Reset clears the sequencer and the configuration; the memories are not cleared.
// A stalled result holds the sequencer in its emit or single step; new items wait for idle.
module clipped_glyph_row_blitter_unit #(
   parameter int GLYPH_WORDS = 4096,
   parameter int TABLE_ENTRIES = 256,
   parameter int MAX_GLYPH_WIDTH = 32,
   parameter int MAX_GLYPH_HEIGHT = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // char_code, pos_x, pos_y, clip_left, clip_top, clip_right, clip_bottom,
   // color, word_address, word_value, glyph_width, unused
   input  logic [cgrb_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // row_y, base_x, write_mask, pixel_color, advance, zero fill
   output logic [cgrb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // row_valid, bad_code
   output logic [1:0] rsp_tuser,
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import cgrb_pkg::*;

   cgrb_cfg_type cfg_ff, cfg_in;
   cgrb_req_type req;
   cgrb_rsp_type rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_CHAR: cfg_in.first_char = csr_wdata;
            CSR_GLYPH_HEIGHT: cfg_in.glyph_height = csr_wdata[5:0];
            CSR_SPACE_WIDTH: cfg_in.space_width = csr_wdata[5:0];
            CSR_MONO_WIDTH: cfg_in.mono_width = csr_wdata[5:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_char <= 8'd32;
         cfg_ff.glyph_height <= 6'd8;
         cfg_ff.space_width <= 6'd4;
         cfg_ff.mono_width <= 6'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req.command = req_tuser;
   assign req.char_code = req_tdata[7:0];
   assign req.pos_x = req_tdata[19:8];
   assign req.pos_y = req_tdata[31:20];
   assign req.clip_left = req_tdata[43:32];
   assign req.clip_top = req_tdata[55:44];
   assign req.clip_right = req_tdata[67:56];
   assign req.clip_bottom = req_tdata[79:68];
   assign req.color = req_tdata[95:80];
   assign req.word_address = req_tdata[107:96];
   assign req.word_value = req_tdata[123:108];
   assign req.glyph_width = req_tdata[129:124];

   cgrb_engine #(
      .GLYPH_WORDS(GLYPH_WORDS),
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH),
      .MAX_GLYPH_HEIGHT(MAX_GLYPH_HEIGHT)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req(req),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp(rsp)
   );

   assign rsp_tdata = {2'b00, rsp.advance, rsp.pixel_color, rsp.write_mask,
                       rsp.base_x, rsp.row_y};
   assign rsp_tuser = {rsp.bad_code, rsp.row_valid};
   assign rsp_tlast = rsp.last;

endmodule
